FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent check forms, clocked on clk_i and quiet in reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PTP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication
`define PTP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: src/ptpet_pkg.sv
// ---------------------------------------------------------------------------
// ptpet_pkg
// constants, widths and the base-2 exponential table of the pet cell core
// ---------------------------------------------------------------------------
`default_nettype none

package ptpet_pkg;

  // pipeline depth from accepted word to result strobe
  localparam int unsigned LATENCY = 43;

  // quotient bits of both restoring dividers
  localparam int unsigned DIV_BITS = 16;

  // exponent argument and scaled exponential widths
  localparam int unsigned U_W   = 17;
  localparam int unsigned E30_W = 38;

  // albedo selection
  localparam logic [15:0] WATER_ALBEDO = 16'd5243;
  localparam logic [15:0] SNOW_LIMIT   = 16'd30;

  // temperature offsets in hundredths of a degree
  localparam logic signed [16:0] TK_OFFSET = 17'sd27315;
  localparam logic signed [16:0] D_OFFSET  = 17'sd23730;

  // tetens exponent in base 2, numerator and denominator scale
  localparam logic [39:0] LOG2E_K   = 40'd1020532465664;
  localparam logic [23:0] DEN_SCALE = 24'd10000000;

  // emission and ratio coefficients
  localparam logic [15:0] RAD_COEF   = 16'd36178;
  localparam logic [25:0] RATIO_COEF = 26'd38508591;

  // exponent bias and output limits
  localparam logic [17:0] U_BIAS  = 18'd57344;
  localparam logic [19:0] OUT_MAX = 20'd131071;
  localparam logic [19:0] OUT_NEG = 20'd131072;

  // 2^(j/64) in q30, j = 0..64
  localparam logic [31:0] ROOT64_Q30 = 32'd1085434106;

  typedef logic [31:0] pow2_rom_t [0:64];

  function automatic pow2_rom_t pow2_rom_f();
    pow2_rom_t r;
    logic [63:0] acc;
    r[0] = 32'h4000_0000;
    acc  = 64'h4000_0000;
    for (int j = 1; j <= 64; j++) begin
      acc  = (acc * 64'(ROOT64_Q30) + 64'h2000_0000) >> 30;
      r[j] = acc[31:0];
    end
    return r;
  endfunction

  localparam pow2_rom_t POW2_ROM = pow2_rom_f();

endpackage

`default_nettype wire

FILE: src/ptpet_pow2.sv
// ---------------------------------------------------------------------------
// ptpet_pow2
// three-stage base-2 exponential: table lookup, linear interpolation, shift
// ---------------------------------------------------------------------------
`default_nettype none

module ptpet_pow2 (
  input  logic                          clk_i,
  input  logic [ptpet_pkg::U_W-1:0]     u_i,
  output logic [ptpet_pkg::E30_W-1:0]   e30_o
);
  import ptpet_pkg::*;

  logic [5:0]  j_c;
  logic [6:0]  j1_c;
  logic [31:0] pj_c, pj1_c;

  logic [4:0]  ia_q, ib_q;
  logic [5:0]  la_q;
  logic [31:0] pja_q;
  logic [25:0] diff_q;
  logic [31:0] m_q;
  logic [31:0] interp_c;
  logic [4:0]  up_c, dn_c;
  logic [E30_W-1:0] e30_q;

  // table reads for the interval around the fraction
  always_comb begin
    j_c   = u_i[11:6];
    j1_c  = {1'b0, j_c} + 7'd1;
    pj_c  = POW2_ROM[j_c];
    pj1_c = POW2_ROM[j1_c];
  end

  // stage a: lookup
  always_ff @(posedge clk_i) begin
    ia_q   <= u_i[16:12];
    la_q   <= u_i[5:0];
    pja_q  <= pj_c;
    diff_q <= 26'(pj1_c - pj_c);
  end

  // stage b: interpolation
  always_comb begin
    interp_c = 32'((32'(diff_q) * 32'(la_q)) >> 6);
  end

  always_ff @(posedge clk_i) begin
    ib_q <= ia_q;
    m_q  <= pja_q + interp_c;
  end

  // stage c: scale by the integer part
  always_comb begin
    up_c = ib_q - 5'd14;
    dn_c = 5'd14 - ib_q;
  end

  always_ff @(posedge clk_i) begin
    if (ib_q >= 5'd14) begin
      e30_q <= E30_W'(m_q) << up_c[2:0];
    end else begin
      e30_q <= E30_W'(m_q) >> dn_c[3:0];
    end
  end

  assign e30_o = e30_q;

endmodule

`default_nettype wire

FILE: src/priestley_taylor_pet_cell_core.sv
// ---------------------------------------------------------------------------
// priestley_taylor_pet_cell_core
// potential evapotranspiration of one grid cell for one day, fixed point
// ---------------------------------------------------------------------------
// channel   direction  handshake             payload
// command   in         start_i, busy_o       mode_i .. pt_coefficient_i
// result    out        done_o (strobe)       potential_evaporation_o
//
// one word accepted per clock, result strobed on done_o after the last stage
// most of the pipeline lies in the two 16-stage restoring dividers (exponent, ratio)
// busy_o stays low: the pipeline never holds, the receiver cannot stall
// reset clears the valid chain only, so no word is in flight afterwards
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module priestley_taylor_pet_cell_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               mode_i,
  input  logic signed [13:0] air_temperature_i,
  input  logic [13:0]        shortwave_radiation_i,
  input  logic [12:0]        longwave_radiation_i,
  input  logic [15:0]        snow_storage_i,
  input  logic [15:0]        land_albedo_i,
  input  logic [15:0]        snow_albedo_i,
  input  logic [15:0]        surface_emissivity_i,
  input  logic [13:0]        pt_coefficient_i,
  output logic               done_o,
  output logic signed [17:0] potential_evaporation_o
);
  import ptpet_pkg::*;

  typedef struct packed {
    logic [54:0] rem;
    logic [15:0] quo;
    logic [38:0] dvs;
    logic        tneg;
  } d1_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [15:0] quo;
    logic [47:0] dvs;
    logic        rneg;
    logic [30:0] mag;
    logic [16:0] a7;
  } d2_t;

  typedef struct packed {
    logic        rneg;
    logic [30:0] mag;
    logic [16:0] a7;
    logic [29:0] d2;
  } side_t;

  function automatic d1_t d1_step(input d1_t s, input int unsigned sh);
    d1_t r;
    logic [54:0] trial;
    r     = s;
    trial = 55'(s.dvs) << sh;
    if (s.rem >= trial) begin
      r.rem = s.rem - trial;
      r.quo = s.quo | (16'd1 << sh);
    end
    return r;
  endfunction

  function automatic d2_t d2_step(input d2_t s, input int unsigned sh);
    d2_t r;
    logic [63:0] trial;
    r     = s;
    trial = 64'(s.dvs) << sh;
    if (s.rem >= trial) begin
      r.rem = s.rem - trial;
      r.quo = s.quo | (16'd1 << sh);
    end
    return r;
  endfunction

  logic                accept;
  logic [LATENCY-1:0]  vld_q;

  // stage 1
  logic [15:0]         alb_c;
  logic [16:0]         alb_cmp_c;
  logic signed [16:0]  t_ext_c, t_negx_c, tk_sum_c, d_sum_c;
  logic [30:0]         albrs_q;
  logic [12:0]         rl1_q;
  logic [31:0]         tk2_q;
  logic [15:0]         emis1_q;
  logic [16:0]         a7_1_q;
  logic                tneg1_q;
  logic [13:0]         tabs_q;
  logic [14:0]         d_q;

  // stage 2
  logic [63:0]         tk4_prod_c;
  logic [31:0]         tk4_q, rqp_q;
  logic [53:0]         num1_q;
  logic [38:0]         dd_q;
  logic [29:0]         d2_2_q;
  logic [15:0]         emis2_q;
  logic [16:0]         a7_2_q;
  logic                tneg2_q;

  // stages 3 to 5, radiation
  logic [47:0]         p1_q;
  logic [31:0]         rqp3_q, rqp4_q;
  logic [16:0]         a7_3_q, a7_4_q;
  logic [29:0]         d2_3_q, d2_4_q;
  logic [63:0]         rad_prod_c;
  logic [27:0]         rad_q;
  logic signed [32:0]  rq_c, rq_neg_c;
  logic [30:0]         mag_c;
  side_t               sd_q [0:19];

  // stages 3 to 18, exponent divider; 19 to 22 exponential
  d1_t                 d1_in_c;
  d1_t                 d1_q [0:DIV_BITS-1];
  logic [16:0]         ymag_c;
  logic [17:0]         u_sum_c;
  logic [U_W-1:0]      u_q;
  logic [E30_W-1:0]    e30;

  // stages 23 to 40, ratio and its divider
  logic [63:0]         num_q, num2_q;
  logic [64:0]         den_sum_c;
  logic [47:0]         den_q;
  d2_t                 d2_in_c;
  d2_t                 d2_q [0:DIV_BITS-1];

  // stages 41 to 43, product, rounding, saturation
  logic [46:0]         pf_q;
  logic [16:0]         a7_41_q;
  logic                rneg41_q, rneg42_q;
  logic [63:0]         pa_q;
  logic [64:0]         rnd_c;
  logic [19:0]         res_c;
  logic [17:0]         out_c;
  logic [17:0]         out_q;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LATENCY-2:0], accept};
    end
  end

  // albedo choice and temperature terms
  always_comb begin
    if (mode_i) begin
      alb_c = WATER_ALBEDO;
    end else if (snow_storage_i > SNOW_LIMIT) begin
      alb_c = snow_albedo_i;
    end else begin
      alb_c = land_albedo_i;
    end
    alb_cmp_c = 17'h1_0000 - {1'b0, alb_c};
    t_ext_c   = 17'(air_temperature_i);
    t_negx_c  = -t_ext_c;
    tk_sum_c  = t_ext_c + TK_OFFSET;
    d_sum_c   = t_ext_c + D_OFFSET;
  end

  // stage 1
  always_ff @(posedge clk_i) begin
    albrs_q <= 31'(alb_cmp_c) * 31'(shortwave_radiation_i);
    rl1_q   <= longwave_radiation_i;
    tk2_q   <= 32'(tk_sum_c[15:0]) * 32'(tk_sum_c[15:0]);
    emis1_q <= surface_emissivity_i;
    a7_1_q  <= 17'(pt_coefficient_i) * 17'd7;
    tneg1_q <= air_temperature_i[13];
    tabs_q  <= air_temperature_i[13] ? t_negx_c[13:0] : air_temperature_i[13:0];
    d_q     <= d_sum_c[14:0];
  end

  // stage 2
  assign tk4_prod_c = 64'(tk2_q) * 64'(tk2_q);

  always_ff @(posedge clk_i) begin
    tk4_q   <= tk4_prod_c[61:30];
    rqp_q   <= 32'(albrs_q) + {3'b000, rl1_q, 16'h0000};
    num1_q  <= 54'(tabs_q) * 54'(LOG2E_K);
    dd_q    <= 39'(d_q) * 39'(DEN_SCALE);
    d2_2_q  <= 30'(d_q) * 30'(d_q);
    emis2_q <= emis1_q;
    a7_2_q  <= a7_1_q;
    tneg2_q <= tneg1_q;
  end

  // stages 3 and 4: emitted radiation
  assign rad_prod_c = 64'(p1_q) * 64'(RAD_COEF);

  always_ff @(posedge clk_i) begin
    p1_q   <= 48'(tk4_q) * 48'(emis2_q);
    rqp3_q <= rqp_q;
    a7_3_q <= a7_2_q;
    d2_3_q <= d2_2_q;
    rad_q  <= rad_prod_c[63:36];
    rqp4_q <= rqp3_q;
    a7_4_q <= a7_3_q;
    d2_4_q <= d2_3_q;
  end

  // stage 5: net radiation as sign and magnitude
  always_comb begin
    rq_c     = $signed({1'b0, rqp4_q}) - $signed({5'b00000, rad_q});
    rq_neg_c = -rq_c;
    mag_c    = rq_c[32] ? rq_neg_c[30:0] : rq_c[30:0];
  end

  // side data, stages 5 to 24
  always_ff @(posedge clk_i) begin
    sd_q[0] <= '{rneg: rq_c[32], mag: mag_c, a7: a7_4_q, d2: d2_4_q};
    for (int n = 1; n < 20; n++) begin
      sd_q[n] <= sd_q[n-1];
    end
  end

  // exponent divider, one quotient bit a stage
  assign d1_in_c = '{rem: 55'(num1_q), quo: '0, dvs: dd_q, tneg: tneg2_q};

  always_ff @(posedge clk_i) begin
    d1_q[0] <= d1_step(d1_in_c, DIV_BITS - 1);
    for (int unsigned k = 1; k < DIV_BITS; k++) begin
      d1_q[k] <= d1_step(d1_q[k-1], DIV_BITS - 1 - k);
    end
  end

  // stage 19: floored exponent plus bias, a remainder rounds a negative one down
  always_comb begin
    ymag_c  = 17'(d1_q[DIV_BITS-1].quo)
            + 17'(d1_q[DIV_BITS-1].tneg & (|d1_q[DIV_BITS-1].rem));
    u_sum_c = (d1_q[DIV_BITS-1].tneg ? (18'd0 - {1'b0, ymag_c}) : {1'b0, ymag_c}) + U_BIAS;
  end

  always_ff @(posedge clk_i) begin
    u_q <= u_sum_c[U_W-1:0];
  end

  // stages 20 to 22
  ptpet_pow2 u_pow2 (
    .clk_i (clk_i),
    .u_i   (u_q),
    .e30_o (e30)
  );

  // stages 23 and 24: ratio numerator and denominator
  assign den_sum_c = {1'b0, num_q} + {5'b00000, sd_q[18].d2, 30'h0};

  always_ff @(posedge clk_i) begin
    num_q  <= 64'(e30) * 64'(RATIO_COEF);
    num2_q <= num_q;
    den_q  <= den_sum_c[63:16];
  end

  // ratio divider, stages 25 to 40
  assign d2_in_c = '{rem: num2_q, quo: '0, dvs: den_q, rneg: sd_q[19].rneg,
                     mag: sd_q[19].mag, a7: sd_q[19].a7};

  always_ff @(posedge clk_i) begin
    d2_q[0] <= d2_step(d2_in_c, DIV_BITS - 1);
    for (int unsigned k = 1; k < DIV_BITS; k++) begin
      d2_q[k] <= d2_step(d2_q[k-1], DIV_BITS - 1 - k);
    end
  end

  // stages 41 and 42: scale by ratio and coefficient
  always_ff @(posedge clk_i) begin
    pf_q     <= 47'(d2_q[DIV_BITS-1].mag) * 47'(d2_q[DIV_BITS-1].quo);
    a7_41_q  <= d2_q[DIV_BITS-1].a7;
    rneg41_q <= d2_q[DIV_BITS-1].rneg;
    pa_q     <= 64'(pf_q) * 64'(a7_41_q);
    rneg42_q <= rneg41_q;
  end

  // stage 43: round half away from zero and saturate
  always_comb begin
    rnd_c = {1'b0, pa_q} + (65'd1 << 44);
    res_c = rnd_c[64:45];
    if (!rneg42_q) begin
      out_c = (res_c > OUT_MAX) ? OUT_MAX[17:0] : res_c[17:0];
    end else if (res_c >= OUT_NEG) begin
      out_c = OUT_NEG[17:0];
    end else begin
      out_c = 18'd0 - res_c[17:0];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_c;
  end

  assign done_o                  = vld_q[LATENCY-1];
  assign potential_evaporation_o = $signed(out_q);

  // checks
  `PTP_ASSERT_IMP(a_word_out, accept, ##LATENCY done_o)
  `PTP_ASSERT_NXT(a_div1_range, vld_q[1], d1_q[0].rem < (55'(d1_q[0].dvs) << 15))
  `PTP_ASSERT_IMP(a_div1_rem, vld_q[17], d1_q[DIV_BITS-1].rem < 55'(d1_q[DIV_BITS-1].dvs))
  `PTP_ASSERT_IMP(a_div2_rem, vld_q[39], d2_q[DIV_BITS-1].rem < 64'(d2_q[DIV_BITS-1].dvs))

endmodule

`default_nettype wire

FILE: tb/pet_cell_checker.sv
// ---------------------------------------------------------------------------
// pet_cell_checker
// watches the command and result channels of the pet cell core, works out
// the expected evapotranspiration of every accepted word and compares it
// with the strobed results in order
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pet_cell_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic               mode_i,
  input  logic signed [13:0] air_temperature_i,
  input  logic [13:0]        shortwave_radiation_i,
  input  logic [12:0]        longwave_radiation_i,
  input  logic [15:0]        snow_storage_i,
  input  logic [15:0]        land_albedo_i,
  input  logic [15:0]        snow_albedo_i,
  input  logic [15:0]        surface_emissivity_i,
  input  logic [13:0]        pt_coefficient_i,
  input  logic               done_i,
  input  logic signed [17:0] potential_evaporation_i,
  input  logic               final_check_i,
  output int                 pending_o,
  output int                 error_count_o
);

  // 2^(j/64) in q30, built independently of the design
  longint unsigned root_tbl [0:64];
  logic signed [17:0] pet_queue [$];

  initial begin
    root_tbl[0] = 64'h4000_0000;
    for (int j = 1; j <= 64; j++)
      root_tbl[j] = (root_tbl[j-1] * 64'd1085434106 + 64'h2000_0000) >> 30;
  end

  initial error_count_o = 0;
  assign pending_o = pet_queue.size();

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count_o++;
  endtask

  // expected evapotranspiration of one cell word
  function automatic logic signed [17:0] predict_pet(
    input logic mode, input logic signed [13:0] temp, input logic [13:0] rs,
    input logic [12:0] rl, input logic [15:0] snow, input logic [15:0] alb_land,
    input logic [15:0] alb_snow, input logic [15:0] emis, input logic [13:0] alpha);
    longint unsigned alb, tk, tk2, rad, u, i, j, l, m, e30, num, g, den, f, mag, res;
    longint t, d, nn, dd, y, rq, val;
    t = temp;
    if (mode) alb = 5243;
    else alb = (snow > 16'd30) ? alb_snow : alb_land;
    // net radiation, q16 tenths of w/m2
    tk  = longint'(t + 27315);
    tk2 = tk * tk;
    rad = (((tk2 * tk2) >> 30) * longint'(emis) * 64'd36178) >> 36;
    rq  = longint'((64'd65536 - alb) * longint'(rs) + (longint'(rl) << 16)) - longint'(rad);
    // base-2 exponent, floor division
    d  = t + 23730;
    nn = t * 64'sd249153434 * 64'sd4096;
    dd = d * 64'sd10000000;
    y  = nn / dd;
    if ((nn % dd) != 0 && nn < 0) y = y - 1;
    u = longint'(y + 57344);
    i = u >> 12;
    j = (u & 64'd4095) >> 6;
    l = u & 64'd63;
    m = root_tbl[j] + (((root_tbl[j+1] - root_tbl[j]) * l) >> 6);
    if (i >= 14) e30 = m << ((i - 14) & 7);
    else e30 = m >> ((14 - i) & 15);
    // slope ratio in q16
    num = e30 * 64'd38508591;
    g   = longint'(d * d) << 30;
    den = (num + g) >> 16;
    f   = (den != 0) ? num / den : 0;
    // scale magnitude, round, restore sign and saturate
    mag = (rq < 0) ? longint'(-rq) : longint'(rq);
    res = (mag * f * longint'(alpha) * 64'd7 + (64'd1 << 44)) >> 45;
    if (res > 64'd131072) res = 64'd131072;
    val = (rq < 0) ? -longint'(res) : longint'(res);
    if (val > 131071) val = 131071;
    if (val < -131072) val = -131072;
    return val[17:0];
  endfunction

  // accepted words and strobed results
  always @(posedge clk_i) begin
    logic signed [17:0] want;
    if (rst_ni) begin
      if (start_i && !busy_i)
        pet_queue.push_back(predict_pet(mode_i, air_temperature_i, shortwave_radiation_i,
          longwave_radiation_i, snow_storage_i, land_albedo_i, snow_albedo_i,
          surface_emissivity_i, pt_coefficient_i));
      if (done_i) begin
        if (pet_queue.size() == 0)
          report_mismatch($sformatf("unexpected result %0d", potential_evaporation_i));
        else begin
          want = pet_queue.pop_front();
          if (potential_evaporation_i !== want)
            report_mismatch($sformatf("potential_evaporation got %0d want %0d",
              potential_evaporation_i, want));
        end
      end
    end
  end

  // leftover expectations at end of run
  always @(posedge final_check_i) begin
    if (pet_queue.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pet_queue.size()));
  end

endmodule

FILE: tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// drives cell words into the pet cell core through directed and random
// phases with varying sender gaps and gives the verdict of the checker
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import ptpet_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic               mode_i = 1'b0;
  logic signed [13:0] air_temperature_i = '0;
  logic [13:0]        shortwave_radiation_i = '0;
  logic [12:0]        longwave_radiation_i = '0;
  logic [15:0]        snow_storage_i = '0;
  logic [15:0]        land_albedo_i = '0;
  logic [15:0]        snow_albedo_i = '0;
  logic [15:0]        surface_emissivity_i = '0;
  logic [13:0]        pt_coefficient_i = '0;
  logic               done_o;
  logic signed [17:0] potential_evaporation_o;
  logic               final_check = 1'b0;
  int                 pending;
  int                 error_count;
  int                 cycle_count = 0;
  int                 gap_pct = 0;

  priestley_taylor_pet_cell_core u_dut (.*);

  pet_cell_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .mode_i, .air_temperature_i,
    .shortwave_radiation_i, .longwave_radiation_i, .snow_storage_i, .land_albedo_i,
    .snow_albedo_i, .surface_emissivity_i, .pt_coefficient_i, .done_i(done_o),
    .potential_evaporation_i(potential_evaporation_o), .final_check_i(final_check),
    .pending_o(pending), .error_count_o(error_count)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // run-time guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // idle each cycle with the phase's chance, then present one word until taken
  task automatic send_word(input logic md, input logic [13:0] t, input logic [13:0] rs,
    input logic [12:0] rl, input logic [15:0] sn, input logic [15:0] al,
    input logic [15:0] as, input logic [15:0] em, input logic [13:0] pt);
    while ($urandom_range(99) < gap_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    mode_i <= md;
    air_temperature_i <= t;
    shortwave_radiation_i <= rs;
    longwave_radiation_i <= rl;
    snow_storage_i <= sn;
    land_albedo_i <= al;
    snow_albedo_i <= as;
    surface_emissivity_i <= em;
    pt_coefficient_i <= pt;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic send_random();
    logic [13:0] t;
    logic [15:0] sn;
    if ($urandom_range(3) == 0) t = 14'($urandom);
    else t = 14'($signed($urandom_range(12000)) - 6000);
    case ($urandom_range(3))
      0: sn = 16'($urandom_range(40, 20));
      1: sn = 16'($urandom);
      default: sn = 16'($urandom_range(200));
    endcase
    send_word(1'($urandom), t,
      $urandom_range(3) == 0 ? 14'($urandom) : 14'($urandom_range(15000)),
      $urandom_range(3) == 0 ? 13'($urandom) : 13'($urandom_range(8000)),
      sn, 16'($urandom), 16'($urandom), 16'($urandom),
      $urandom_range(3) == 0 ? 14'($urandom) : 14'($urandom_range(12288)));
  endtask

  initial begin
    int phase_pct [4] = '{0, 54, 0, 18};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words: field extremes, water and land, snow threshold
    send_word(1'b0, 14'sd0, 14'd0, 13'd0, 16'd0, 16'd0, 16'd0, 16'd0, 14'd0);
    send_word(1'b1, -14'sd6000, 14'd15000, 13'd8000, 16'd0, 16'd0, 16'd0, 16'hffff, 14'd12288);
    send_word(1'b1, 14'sd6000, 14'd15000, 13'd8000, 16'd0, 16'd0, 16'd0, 16'd0, 14'd12288);
    send_word(1'b0, -14'sd8192, 14'h3fff, 13'h1fff, 16'd30, 16'hffff, 16'd0, 16'hffff, 14'h3fff);
    send_word(1'b0, 14'sd8191, 14'h3fff, 13'h1fff, 16'd31, 16'hffff, 16'd0, 16'd0, 14'h3fff);
    send_word(1'b0, 14'sd8191, 14'h3fff, 13'h1fff, 16'hffff, 16'd0, 16'hffff, 16'd0, 14'h3fff);
    send_word(1'b0, 14'sd2500, 14'd8000, 13'd3500, 16'd30, 16'd13107, 16'd52428, 16'd62914,
      14'd5161);
    send_word(1'b0, 14'sd2500, 14'd8000, 13'd3500, 16'd31, 16'd13107, 16'd52428, 16'd62914,
      14'd5161);
    send_word(1'b1, 14'sd2500, 14'd8000, 13'd3500, 16'd31, 16'd13107, 16'd52428, 16'd62914,
      14'd5161);
    send_word(1'b0, -14'sd1000, 14'd0, 13'd0, 16'd0, 16'd0, 16'd0, 16'hffff, 14'h3fff);
    send_word(1'b0, 14'sd4000, 14'd0, 13'd1000, 16'd0, 16'd0, 16'd0, 16'hffff, 14'd12288);
    send_word(1'b0, 14'sd0, 14'd15000, 13'd0, 16'd0, 16'hffff, 16'd0, 16'd0, 14'd4096);

    // hold off until the pipeline has drained
    start_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);

    // random phases with differing sender gaps
    for (int p = 0; p < 4; p++) begin
      gap_pct = phase_pct[p];
      repeat (210) send_random();
    end
    start_i <= 1'b0;

    // drain and settle
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    final_check <= 1'b1;
    @(posedge clk_i);
    @(posedge clk_i);
    if (error_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
